FILE: src/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, constants and codes for the dirty rectangle tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int EDGE_W      = 12;
    localparam int COORD_W     = 16;

    localparam logic [EDGE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [EDGE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // request op codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // add outcome codes
    localparam logic [2:0] ADD_NONE   = 3'd0;
    localparam logic [2:0] ADD_EMPTY  = 3'd1;
    localparam logic [2:0] ADD_MERGED = 3'd2;
    localparam logic [2:0] ADD_NEW    = 3'd3;
    localparam logic [2:0] ADD_FORCED = 3'd4;

    typedef struct packed {
        logic [1:0]                op;
        logic [2:0]                entry_index;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] bottom_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] top_y;
    } t_req;

    typedef struct packed {
        logic              any_valid;
        logic [2:0]        add_outcome;
        logic              read_valid;
        logic [EDGE_W-1:0] read_left;
        logic [EDGE_W-1:0] read_bottom;
        logic [EDGE_W-1:0] read_right;
        logic [EDGE_W-1:0] read_top;
    } t_rsp;

    typedef struct packed {
        logic [EDGE_W-1:0] left;
        logic [EDGE_W-1:0] bottom;
        logic [EDGE_W-1:0] right;
        logic [EDGE_W-1:0] top;
    } t_rect;

    typedef struct packed {
        logic  overlap;
        t_rect joined;
    } t_cmp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_SCAN,
        S_PLACE,
        S_FINISH
    } t_state;

endpackage

FILE: src/drt_rect_unit.sv
// ----------------------------------------------------------------------------
// drt_rect_unit
// Shared compare and union unit: overlap test of two rectangles and their
// bounding union.
// ----------------------------------------------------------------------------
module drt_rect_unit (
    input  drt_pkg::t_rect i_a,
    input  drt_pkg::t_rect i_b,
    output drt_pkg::t_cmp  o_cmp
);

    // strict half-open intersection
    assign o_cmp.overlap = (i_a.left < i_b.right) && (i_b.left < i_a.right) &&
                           (i_a.bottom < i_b.top) && (i_b.bottom < i_a.top);

    assign o_cmp.joined.left   = (i_a.left < i_b.left) ? i_a.left : i_b.left;
    assign o_cmp.joined.bottom = (i_a.bottom < i_b.bottom) ? i_a.bottom : i_b.bottom;
    assign o_cmp.joined.right  = (i_a.right > i_b.right) ? i_a.right : i_b.right;
    assign o_cmp.joined.top    = (i_a.top > i_b.top) ? i_a.top : i_b.top;

endmodule

FILE: src/dirty_rectangle_tracker.sv
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker
// Table of invalidated screen rectangles with add, clear and read requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  request   in         i_req_valid / o_req_ready      i_req (t_req)
//  response  out        o_rsp_valid / i_rsp_ready      o_rsp (t_rsp)
//  config    in         i_cfg_wr_en (no wait)          i_cfg_index, i_cfg_data
//
//  clear, read and unused ops go from accept straight to the finish step; an add
//  passes the clamp step and, unless empty, the scan and place steps: the scan takes one
//  entry per cycle through the shared rect unit, restarting at entry 0 after each merge.
//  ready returns the cycle after the response is loaded; o_req_ready is high only
//  in idle, and a response still waiting holds the next request in its last step.
//  reset clears the valid bits and restores the frame size; bounds are not reset.
// ----------------------------------------------------------------------------
module dirty_rectangle_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  drt_pkg::t_req                   i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output drt_pkg::t_rsp                   o_rsp,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [drt_pkg::EDGE_W-1:0]      i_cfg_data
);

    localparam int N  = drt_pkg::NUM_ENTRIES;
    localparam int IW = drt_pkg::IDX_W;
    localparam int EW = drt_pkg::EDGE_W;

    drt_pkg::t_state r_state, n_state;
    drt_pkg::t_req   r_req, n_req;
    drt_pkg::t_rect  r_rect, n_rect;
    drt_pkg::t_rect  r_bounds [N];
    drt_pkg::t_rect  n_bounds [N];
    drt_pkg::t_rsp   r_rsp, n_rsp;
    logic [N-1:0]    r_valid, n_valid;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_rd_hit, n_rd_hit;
    logic            r_merged, n_merged;
    logic [2:0]      r_outcome, n_outcome;
    logic            r_rsp_valid, n_rsp_valid;
    logic [EW-1:0]   r_fw, r_fh;

    drt_pkg::t_cmp   c_cmp;
    logic            c_empty;
    logic            c_hit;
    logic            c_any_free;
    logic [IW-1:0]   c_free_idx;
    logic [5:0]      c_rd_ext;
    logic signed [16:0] c_lx, c_by, c_rx, c_ty, c_fw, c_fh;

    drt_rect_unit u_rect (
        .i_a   (r_bounds[r_idx]),
        .i_b   (r_rect),
        .o_cmp (c_cmp)
    );

    // clamp the registered request to the frame
    always_comb begin
        c_fw  = $signed({5'b0, r_fw});
        c_fh  = $signed({5'b0, r_fh});
        c_lx  = r_req.left_x[15] ? 17'sd0 : $signed({1'b0, r_req.left_x});
        c_by  = r_req.bottom_y[15] ? 17'sd0 : $signed({1'b0, r_req.bottom_y});
        c_rx  = $signed({r_req.right_x[15], r_req.right_x});
        c_ty  = $signed({r_req.top_y[15], r_req.top_y});
        if (c_rx > c_fw) begin
            c_rx = c_fw;
        end
        if (c_ty > c_fh) begin
            c_ty = c_fh;
        end
        c_empty = (c_lx >= c_rx) || (c_by >= c_ty);
    end

    always_comb begin
        c_any_free = 1'b0;
        c_free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                c_any_free = 1'b1;
                c_free_idx = IW'(i);
            end
        end
    end

    assign c_hit    = r_valid[r_idx] && c_cmp.overlap;
    assign c_rd_ext = {3'b0, i_req.entry_index};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            drt_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req.op == drt_pkg::OP_ADD) ? drt_pkg::S_CLAMP
                                                            : drt_pkg::S_FINISH;
                end
            end
            drt_pkg::S_CLAMP: begin
                n_state = c_empty ? drt_pkg::S_FINISH : drt_pkg::S_SCAN;
            end
            drt_pkg::S_SCAN: begin
                if (!c_hit && r_idx == IW'(N - 1)) begin
                    n_state = drt_pkg::S_PLACE;
                end
            end
            drt_pkg::S_PLACE: begin
                n_state = drt_pkg::S_FINISH;
            end
            drt_pkg::S_FINISH: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_state = drt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = drt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req       = r_req;
        n_rect      = r_rect;
        n_bounds    = r_bounds;
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_rd_hit    = r_rd_hit;
        n_merged    = r_merged;
        n_outcome   = r_outcome;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_req_ready = 1'b0;
        case (r_state)
            drt_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_outcome = drt_pkg::ADD_NONE;
                    n_idx     = c_rd_ext[IW-1:0];
                    n_rd_hit  = c_rd_ext < 6'(N);
                    if (i_req.op == drt_pkg::OP_CLEAR) begin
                        n_valid = '0;
                    end
                end
            end
            drt_pkg::S_CLAMP: begin
                n_rect.left   = c_lx[EW-1:0];
                n_rect.bottom = c_by[EW-1:0];
                n_rect.right  = c_rx[EW-1:0];
                n_rect.top    = c_ty[EW-1:0];
                n_idx         = '0;
                n_merged      = 1'b0;
                if (c_empty) begin
                    n_outcome = drt_pkg::ADD_EMPTY;
                end
            end
            drt_pkg::S_SCAN: begin
                if (c_hit) begin
                    // absorb the entry and restart the search
                    n_valid[r_idx] = 1'b0;
                    n_rect         = c_cmp.joined;
                    n_merged       = 1'b1;
                    n_idx          = '0;
                end else if (r_idx == IW'(N - 1)) begin
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            drt_pkg::S_PLACE: begin
                if (c_any_free) begin
                    n_valid[c_free_idx]  = 1'b1;
                    n_bounds[c_free_idx] = r_rect;
                    n_outcome = r_merged ? drt_pkg::ADD_MERGED : drt_pkg::ADD_NEW;
                end else begin
                    // table full: r_idx is zero here, so the unit joins entry zero
                    n_bounds[0] = c_cmp.joined;
                    n_outcome   = drt_pkg::ADD_FORCED;
                end
            end
            drt_pkg::S_FINISH: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid       = 1'b1;
                    n_rsp             = '0;
                    n_rsp.any_valid   = |r_valid;
                    n_rsp.add_outcome = r_outcome;
                    if (r_req.op == drt_pkg::OP_READ && r_rd_hit && r_valid[r_idx]) begin
                        n_rsp.read_valid  = 1'b1;
                        n_rsp.read_left   = r_bounds[r_idx].left;
                        n_rsp.read_bottom = r_bounds[r_idx].bottom;
                        n_rsp.read_right  = r_bounds[r_idx].right;
                        n_rsp.read_top    = r_bounds[r_idx].top;
                    end
                end
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drt_pkg::S_IDLE;
            r_valid     <= '0;
            r_rsp_valid <= 1'b0;
            r_fw        <= drt_pkg::FRAME_WIDTH_RST;
            r_fh        <= drt_pkg::FRAME_HEIGHT_RST;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    drt_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                    drt_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                    default: begin
                        r_fw <= r_fw;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rect    <= n_rect;
        r_bounds  <= n_bounds;
        r_idx     <= n_idx;
        r_rd_hit  <= n_rd_hit;
        r_merged  <= n_merged;
        r_outcome <= n_outcome;
        r_rsp     <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // a stored or joined rectangle leaves at least one entry valid
    a_add_leaves_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.add_outcome == drt_pkg::ADD_MERGED ||
                        o_rsp.add_outcome == drt_pkg::ADD_NEW ||
                        o_rsp.add_outcome == drt_pkg::ADD_FORCED)
        |-> o_rsp.any_valid)
        else $error("add stored a rectangle but no entry is valid");

    // entries only ever hold non-empty rectangles
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.read_valid
        |-> (o_rsp.read_left < o_rsp.read_right) && (o_rsp.read_bottom < o_rsp.read_top))
        else $error("read returned an empty rectangle");

    // forcing into entry zero needs the scan pointer parked at zero
    a_place_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == drt_pkg::S_PLACE |-> r_idx == '0)
        else $error("place step entered with nonzero entry pointer");

    // a merge sends the scan back to entry zero
    a_restart_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == drt_pkg::S_SCAN && c_hit |=> r_idx == '0 && r_merged)
        else $error("scan did not restart after a merge");

endmodule

FILE: tb/rect_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_table_checker
// Watches the request and response channels of the dirty rectangle tracker,
// keeps its own copy of the rectangle table and frame size, works out the
// response of every accepted request and compares it field by field with
// what the block returns, in order.
// ----------------------------------------------------------------------------
module rect_table_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  drt_pkg::t_req              i_req,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    input  drt_pkg::t_rsp              i_rsp,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_index,
    input  logic [drt_pkg::EDGE_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    localparam int EW = drt_pkg::EDGE_W;
    localparam int NE = drt_pkg::NUM_ENTRIES;

    logic [EW-1:0]          frame_w;
    logic [EW-1:0]          frame_h;
    logic [NE-1:0]          live_mask;
    int                     box_left   [NE];
    int                     box_bottom [NE];
    int                     box_right  [NE];
    int                     box_top    [NE];
    drt_pkg::t_rsp          table_replies [$];

    // updates the table copy and returns the response the request should get
    function automatic drt_pkg::t_rsp apply_to_table(input drt_pkg::t_req r);
        drt_pkg::t_rsp res;
        int   lx, by, rx, ty;
        int   slot;
        bit   joined, hit;
        res = '0;
        case (r.op)
            drt_pkg::OP_ADD: begin
                lx = $signed(r.left_x);
                by = $signed(r.bottom_y);
                rx = $signed(r.right_x);
                ty = $signed(r.top_y);
                if (lx < 0) lx = 0;
                if (by < 0) by = 0;
                if (rx > int'(frame_w)) rx = int'(frame_w);
                if (ty > int'(frame_h)) ty = int'(frame_h);
                if (lx >= rx || by >= ty) begin
                    res.add_outcome = drt_pkg::ADD_EMPTY;
                end else begin
                    joined = 0;
                    // absorb the lowest overlapping entry, then rescan from zero
                    do begin
                        hit = 0;
                        for (int i = 0; i < NE; i++) begin
                            if (!hit && live_mask[i] &&
                                box_left[i] < rx && lx < box_right[i] &&
                                box_bottom[i] < ty && by < box_top[i]) begin
                                live_mask[i] = 1'b0;
                                lx = (box_left[i]   < lx) ? box_left[i]   : lx;
                                by = (box_bottom[i] < by) ? box_bottom[i] : by;
                                rx = (box_right[i]  > rx) ? box_right[i]  : rx;
                                ty = (box_top[i]    > ty) ? box_top[i]    : ty;
                                hit    = 1;
                                joined = 1;
                            end
                        end
                    end while (hit);
                    slot = -1;
                    for (int i = 0; i < NE; i++)
                        if (slot < 0 && !live_mask[i]) slot = i;
                    if (slot >= 0) begin
                        live_mask[slot]  = 1'b1;
                        box_left[slot]   = lx;
                        box_bottom[slot] = by;
                        box_right[slot]  = rx;
                        box_top[slot]    = ty;
                        res.add_outcome  = joined ? drt_pkg::ADD_MERGED : drt_pkg::ADD_NEW;
                    end else begin
                        // table full and nothing overlapped: grow entry zero
                        box_left[0]   = (lx < box_left[0])   ? lx : box_left[0];
                        box_bottom[0] = (by < box_bottom[0]) ? by : box_bottom[0];
                        box_right[0]  = (rx > box_right[0])  ? rx : box_right[0];
                        box_top[0]    = (ty > box_top[0])    ? ty : box_top[0];
                        res.add_outcome = drt_pkg::ADD_FORCED;
                    end
                end
            end
            drt_pkg::OP_CLEAR: begin
                live_mask = '0;
            end
            drt_pkg::OP_READ: begin
                if (r.entry_index < NE && live_mask[r.entry_index]) begin
                    res.read_valid  = 1'b1;
                    res.read_left   = EW'(box_left[r.entry_index]);
                    res.read_bottom = EW'(box_bottom[r.entry_index]);
                    res.read_right  = EW'(box_right[r.entry_index]);
                    res.read_top    = EW'(box_top[r.entry_index]);
                end
            end
            default: begin
            end
        endcase
        res.any_valid = |live_mask;
        return res;
    endfunction

    function automatic string show(input drt_pkg::t_rsp r);
        return $sformatf("any=%0d add=%0d rd=%0d l=%0d b=%0d r=%0d t=%0d",
                         r.any_valid, r.add_outcome, r.read_valid, r.read_left,
                         r.read_bottom, r.read_right, r.read_top);
    endfunction

    always @(posedge i_clk) begin
        drt_pkg::t_rsp want;
        if (!i_rst_n) begin
            frame_w      = drt_pkg::FRAME_WIDTH_RST;
            frame_h      = drt_pkg::FRAME_HEIGHT_RST;
            live_mask    = '0;
            o_fail_count = 0;
            o_checked    = 0;
            table_replies.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == drt_pkg::CFG_FRAME_WIDTH)
                    frame_w = i_cfg_data;
                else
                    frame_h = i_cfg_data;
            end
            if (i_req_valid && i_req_ready)
                table_replies.push_back(apply_to_table(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (table_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: response with no request waiting: %s",
                                 $realtime, show(i_rsp));
                end else begin
                    want = table_replies.pop_front();
                    o_checked++;
                    if (i_rsp.any_valid   !== want.any_valid   ||
                        i_rsp.add_outcome !== want.add_outcome ||
                        i_rsp.read_valid  !== want.read_valid  ||
                        i_rsp.read_left   !== want.read_left   ||
                        i_rsp.read_bottom !== want.read_bottom ||
                        i_rsp.read_right  !== want.read_right  ||
                        i_rsp.read_top    !== want.read_top) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: response mismatch\n  exp %s\n  got %s",
                                     $realtime, show(want), show(i_rsp));
                    end
                end
            end
        end
        o_pending = table_replies.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dirty rectangle tracker: a directed sequence
// covering clamping, empty drops, strict edges, forced merges and chained
// merges, then random requests over a series of frame sizes with random
// gaps on both channels. Checking is done by rect_table_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         EW          = drt_pkg::EDGE_W;
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         QUIET_LIMIT = 1000;
    localparam int         NUM_PHASES  = 9;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    drt_pkg::t_req     req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    drt_pkg::t_rsp     rsp;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = drt_pkg::CFG_FRAME_WIDTH;
    logic [EW-1:0]     cfg_data  = '0;

    int fail_count, pending, checked;
    int fw = 640;
    int fh = 480;
    bit steady = 0;
    int stall_left = 0;
    int quiet = 0;
    int n_add, n_read, n_clear, n_spare;

    // -1 stands for a random size
    int phase_w [NUM_PHASES] = '{4095, 1, 0, 37, 4095, 1, 320, 200, -1};
    int phase_h [NUM_PHASES] = '{4095, 1, 480, 23, 1, 4095, 0, 150, -1};

    always #5 clk = ~clk;

    dirty_rectangle_tracker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rect_table_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic drt_pkg::t_req mk(input logic [1:0] op, input int idx,
                                input int lx, input int by, input int rx, input int ty);
        drt_pkg::t_req r;
        r.op          = op;
        r.entry_index = 3'(idx);
        r.left_x      = 16'(lx);
        r.bottom_y    = 16'(by);
        r.right_x     = 16'(rx);
        r.top_y       = 16'(ty);
        return r;
    endfunction

    function automatic drt_pkg::t_req random_req();
        drt_pkg::t_req r;
        int   pick, lx, by;
        pick          = $urandom_range(0, 99);
        r.op          = drt_pkg::OP_ADD;
        r.entry_index = 3'($urandom_range(0, 7));
        r.left_x      = 16'($urandom);
        r.bottom_y    = 16'($urandom);
        r.right_x     = 16'($urandom);
        r.top_y       = 16'($urandom);
        if (pick < 55) begin
            // well-formed rectangle with its lower left corner inside the frame, tiny or up to a quarter
            lx = $urandom_range(0, (fw > 0) ? fw - 1 : 0);
            by = $urandom_range(0, (fh > 0) ? fh - 1 : 0);
            r.left_x   = 16'(lx);
            r.bottom_y = 16'(by);
            if ($urandom_range(0, 1)) begin
                r.right_x = 16'(lx + $urandom_range(1, 8));
                r.top_y   = 16'(by + $urandom_range(1, 8));
            end else begin
                r.right_x = 16'(lx + $urandom_range(1, fw / 4 + 1));
                r.top_y   = 16'(by + $urandom_range(1, fh / 4 + 1));
            end
        end else if (pick < 63) begin
            // fully random coordinates
        end else if (pick < 70) begin
            // straddles the frame edges
            r.left_x   = 16'(int'($urandom_range(0, 60)) - 30);
            r.bottom_y = 16'(int'($urandom_range(0, 60)) - 30);
            r.right_x  = 16'(fw + int'($urandom_range(0, 60)) - 30);
            r.top_y    = 16'(fh + int'($urandom_range(0, 60)) - 30);
        end else if (pick < 92) begin
            r.op = drt_pkg::OP_READ;
        end else if (pick < 97) begin
            r.op = drt_pkg::OP_CLEAR;
        end else begin
            r.op = OP_SPARE;
        end
        return r;
    endfunction

    task automatic send(input drt_pkg::t_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        case (r.op)
            drt_pkg::OP_ADD:   n_add++;
            drt_pkg::OP_READ:  n_read++;
            drt_pkg::OP_CLEAR: n_clear++;
            default:           n_spare++;
        endcase
    endtask

    // lower the request and wait until every response is back
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_reg(input logic idx, input logic [EW-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // response side back-pressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    // ends the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("no request or response accepted for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int count;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part with the reset frame size
        send(mk(drt_pkg::OP_READ, 0, 0, 0, 0, 0));
        send(mk(drt_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
        send(mk(OP_SPARE, 7, 0, 0, 0, 0));
        send(mk(drt_pkg::OP_ADD, 0, -32768, -32768, 32767, 32767));
        send(mk(drt_pkg::OP_READ, 0, 0, 0, 0, 0));
        send(mk(drt_pkg::OP_ADD, 0, 100, 100, 100, 200));
        send(mk(drt_pkg::OP_ADD, 0, 700, 0, 800, 10));
        send(mk(drt_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
        for (int i = 0; i < drt_pkg::NUM_ENTRIES; i++)
            send(mk(drt_pkg::OP_ADD, 0, i * 10, 0, i * 10 + 5, 5));
        // only touches its neighbors, so the full table forces it into entry zero
        send(mk(drt_pkg::OP_ADD, 0, 5, 0, 10, 5));
        send(mk(drt_pkg::OP_READ, 0, 0, 0, 0, 0));
        send(mk(drt_pkg::OP_ADD, 0, 2, 1, 3, 2));
        send(mk(drt_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
        // third rect hits the second, and their union then hits the first
        send(mk(drt_pkg::OP_ADD, 0, 0, 0, 10, 10));
        send(mk(drt_pkg::OP_ADD, 0, 20, 5, 30, 30));
        send(mk(drt_pkg::OP_ADD, 0, 5, 15, 25, 25));
        send(mk(drt_pkg::OP_READ, 0, 0, 0, 0, 0));
        send(mk(drt_pkg::OP_READ, 1, 0, 0, 0, 0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            fw = (phase_w[ph] < 0) ? $urandom_range(1, 4095) : phase_w[ph];
            fh = (phase_h[ph] < 0) ? $urandom_range(1, 4095) : phase_h[ph];
            write_reg(drt_pkg::CFG_FRAME_WIDTH, EW'(fw));
            write_reg(drt_pkg::CFG_FRAME_HEIGHT, EW'(fh));
            steady = (ph % 3 == 1);
            count  = (fw == 0 || fh == 0) ? 40 : 260;
            repeat (count) send(random_req());
        end

        drain();
        repeat (20) @(posedge clk);
        $display("%0d responses checked: %0d adds, %0d reads, %0d clears, %0d unused ops",
                 checked, n_add, n_read, n_clear, n_spare);
        $display("frame sizes from zero to 4095 on each axis, with and without gaps");
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d failures, %0d responses missing", fail_count, pending);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/drt_pkg.sv
src/drt_rect_unit.sv
src/dirty_rectangle_tracker.sv
tb/rect_table_checker.sv
tb/tb_top.sv
